// ----- rtl/mbd_pkg.sv -----
// Shared types, constants and channel arithmetic for the mip level box-filter downsampler.
// Has no dependencies; every file that uses it refers to it through scoped names.
`default_nettype none

package mbd_pkg;

   // Default size limits of the source level.
   localparam int DEFAULT_MAX_WIDTH  = 2048;
   localparam int DEFAULT_MAX_HEIGHT = 1024;

   // Register widths and reset values.
   localparam int SRC_WIDTH_BITS   = 12;
   localparam int SRC_HEIGHT_BITS  = 11;
   localparam int SRC_WIDTH_RESET  = 2048;
   localparam int SRC_HEIGHT_RESET = 1024;
   localparam int CSR_DATA_W       = 12;
   localparam int CSR_INDEX_W      = 1;

   // Pixel and pair-sum layout.
   localparam int PIXEL_W   = 32;
   localparam int RGB_W     = 24;
   localparam int CHAN_W    = 8;
   localparam int LANE_W    = 9;
   localparam int PAIR_W    = 27;
   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

   // Register indices of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SRC_WIDTH  = 1'b0,
      REG_SRC_HEIGHT = 1'b1
   } csr_reg_type;

   // Item held between the scan stage and the output stage.
   typedef struct packed {
      logic              valid;
      logic              use_self;   // height of one: the pair sum stands for both rows
      logic              last;       // final pixel of the output level
      logic [PAIR_W-1:0] pair;       // pair sums of the current (lower) row
   } stage_type;

   // Horizontal pair sum of two 24-bit pixels, one 9-bit lane per channel.
   function automatic logic [PAIR_W-1:0] pair_of(input logic [RGB_W-1:0] a,
                                                 input logic [RGB_W-1:0] b);
      logic [PAIR_W-1:0] r;
      r = '0;
      for (int i = 0; i < 3; i++) begin
         r[i*LANE_W +: LANE_W] = LANE_W'(a[i*CHAN_W +: CHAN_W]) +
                                 LANE_W'(b[i*CHAN_W +: CHAN_W]);
      end
      return r;
   endfunction

   // Rounded average of two rows of pair sums: floor((sum + 2) / 4) per channel.
   function automatic logic [RGB_W-1:0] finish(input logic [PAIR_W-1:0] top,
                                               input logic [PAIR_W-1:0] bottom);
      logic [RGB_W-1:0]  r;
      logic [LANE_W:0]   s;
      r = '0;
      for (int i = 0; i < 3; i++) begin
         s = (LANE_W+1)'(top[i*LANE_W +: LANE_W]) +
             (LANE_W+1)'(bottom[i*LANE_W +: LANE_W]) + (LANE_W+1)'(2);
         r[i*CHAN_W +: CHAN_W] = s[LANE_W:2];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/mbd_ram.sv -----
// Generic simple dual-port RAM: one write port and one read port with registered read data.
// Self-contained; used for the line store of pair sums.
`default_nettype none

module mbd_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, and a read register that holds its value while no read is issued.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/mbd_scan_ctrl.sv -----
// Scan stage: size registers, column and row counts, horizontal pairing and line store access.
// Depends on mbd_pkg; drives the line store RAM and the stage register read by mbd_out_stage.
`default_nettype none

module mbd_scan_ctrl #(
   parameter int MAX_WIDTH  = mbd_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = mbd_pkg::DEFAULT_MAX_HEIGHT,
   localparam int WW = $clog2(MAX_WIDTH + 1),
   localparam int HW = $clog2(MAX_HEIGHT + 1),
   localparam int AW = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [mbd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [mbd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   input  wire logic [mbd_pkg::PIXEL_W-1:0]       req_tdata,
   output      logic                              line_wr_en,
   output      logic [AW-1:0]                     line_wr_addr,
   output      logic [mbd_pkg::PAIR_W-1:0]        line_wr_data,
   output      logic                              line_rd_en,
   output      logic [AW-1:0]                     line_rd_addr,
   output      mbd_pkg::stage_type                stage,
   input  wire logic                              stage_take
);

   localparam int RESET_W = (mbd_pkg::SRC_WIDTH_RESET > MAX_WIDTH) ?
                            MAX_WIDTH : mbd_pkg::SRC_WIDTH_RESET;
   localparam int RESET_H = (mbd_pkg::SRC_HEIGHT_RESET > MAX_HEIGHT) ?
                            MAX_HEIGHT : mbd_pkg::SRC_HEIGHT_RESET;

   // Output-level size less one: max(size / 2, 1) - 1.
   function automatic logic [WW-1:0] half_w_m1(input logic [WW-1:0] s);
      logic [WW-1:0] h;
      h = s >> 1;
      return (h == '0) ? '0 : h - WW'(1);
   endfunction

   function automatic logic [HW-1:0] half_h_m1(input logic [HW-1:0] s);
      logic [HW-1:0] h;
      h = s >> 1;
      return (h == '0) ? '0 : h - HW'(1);
   endfunction

   logic [WW-1:0] width_ff, width_in, nw_m1_ff, nw_m1_in;
   logic [HW-1:0] height_ff, height_in, nh_m1_ff, nh_m1_in;
   logic [WW-1:0] col_ff, col_in;
   logic [HW-1:0] row_ff, row_in;
   logic [mbd_pkg::RGB_W-1:0] pending_ff, pending_in;
   mbd_pkg::stage_type stage_ff, stage_in;

   logic [31:0] wdata_w, wdata_h, clamp_w, clamp_h;
   logic        accept, w_is_one, h_is_one, have_pair, emit;
   logic [WW-1:0] col_next, x_full;
   logic [HW-1:0] row_next, y_full;
   logic [mbd_pkg::RGB_W-1:0]  px;
   logic [mbd_pkg::PAIR_W-1:0] pair;

   assign accept   = req_tvalid && req_tready;
   assign w_is_one = (width_ff == WW'(1));
   assign h_is_one = (height_ff == HW'(1));
   assign px       = req_tdata[mbd_pkg::RGB_W-1:0];

   // Clamp written sizes into 1..MAX.
   always_comb begin
      wdata_w = 32'(csr_wdata[mbd_pkg::SRC_WIDTH_BITS-1:0]);
      wdata_h = 32'(csr_wdata[mbd_pkg::SRC_HEIGHT_BITS-1:0]);
      clamp_w = (wdata_w == 32'd0) ? 32'd1 :
                (wdata_w > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : wdata_w;
      clamp_h = (wdata_h == 32'd0) ? 32'd1 :
                (wdata_h > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : wdata_h;
   end

   // Pairing, line store addressing and the decision to produce a result.
   always_comb begin
      have_pair = w_is_one || col_ff[0];
      emit      = have_pair && (h_is_one || row_ff[0]);
      pair      = w_is_one ? mbd_pkg::pair_of(px, px) : mbd_pkg::pair_of(pending_ff, px);
      x_full    = col_ff >> 1;
      y_full    = row_ff >> 1;
      col_next  = col_ff + WW'(1);
      row_next  = row_ff + HW'(1);
   end

   // Even rows store pair sums, odd rows read them back; the two never meet on one entry
   // within a row's distance, so no forwarding is needed.
   assign line_wr_en   = accept && have_pair && !h_is_one && !row_ff[0] &&
                         (row_next < height_ff);
   assign line_wr_addr = AW'(x_full);
   assign line_wr_data = pair;
   assign line_rd_en   = accept && emit && !h_is_one;
   assign line_rd_addr = AW'(x_full);

   // The scan stage takes a pixel whenever its stage register is free or being emptied.
   assign req_tready = !stage_ff.valid || stage_take;

   // Next-state logic for counts, sizes, pending pixel and stage register.
   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      nw_m1_in   = nw_m1_ff;
      nh_m1_in   = nh_m1_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      pending_in = pending_ff;
      stage_in   = stage_ff;

      if (stage_take) begin
         stage_in.valid = 1'b0;
      end

      if (accept) begin
         if (!w_is_one && !col_ff[0]) begin
            pending_in = px;
         end
         if (emit) begin
            stage_in.valid    = 1'b1;
            stage_in.use_self = h_is_one;
            stage_in.last     = (x_full == nw_m1_ff) && (y_full == nh_m1_ff);
            stage_in.pair     = pair;
         end
         if (col_next >= width_ff) begin
            col_in = '0;
            row_in = (row_next >= height_ff) ? '0 : row_next;
         end else begin
            col_in = col_next;
         end
      end

      // A register write restarts the level.
      if (csr_we) begin
         col_in = '0;
         row_in = '0;
         case (mbd_pkg::csr_reg_type'(csr_index))
            mbd_pkg::REG_SRC_WIDTH: begin
               width_in = WW'(clamp_w);
               nw_m1_in = half_w_m1(WW'(clamp_w));
            end
            mbd_pkg::REG_SRC_HEIGHT: begin
               height_in = HW'(clamp_h);
               nh_m1_in  = half_h_m1(HW'(clamp_h));
            end
            default: begin
               col_in = '0;
            end
         endcase
      end
   end

   // Control state and stage register with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WW'(RESET_W);
         height_ff  <= HW'(RESET_H);
         nw_m1_ff   <= half_w_m1(WW'(RESET_W));
         nh_m1_ff   <= half_h_m1(HW'(RESET_H));
         col_ff     <= '0;
         row_ff     <= '0;
         pending_ff <= '0;
         stage_ff   <= '0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         nw_m1_ff   <= nw_m1_in;
         nh_m1_ff   <= nh_m1_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         pending_ff <= pending_in;
         stage_ff   <= stage_in;
      end
   end

   assign stage = stage_ff;

endmodule

`default_nettype wire

// ----- rtl/mbd_out_stage.sv -----
// Output stage: joins stored and current pair sums into the averaged pixel and holds it for transfer.
// Depends on mbd_pkg; fed by mbd_scan_ctrl and the line store read data.
`default_nettype none

module mbd_out_stage (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mbd_pkg::stage_type            stage,
   output      logic                          stage_take,
   input  wire logic [mbd_pkg::PAIR_W-1:0]    line_rd_data,
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   output      logic [mbd_pkg::PIXEL_W-1:0]   rsp_tdata,
   output      logic                          rsp_tlast
);

   logic                          valid_ff, valid_in;
   logic [mbd_pkg::PIXEL_W-1:0]   data_ff, data_in;
   logic                          last_ff, last_in;
   logic [mbd_pkg::PAIR_W-1:0]    top;

   // The stage moves on when the output register is empty or its transfer completes.
   assign stage_take = stage.valid && (!valid_ff || rsp_tready);

   // Result of the 2x2 block.
   always_comb begin
      top      = stage.use_self ? stage.pair : line_rd_data;
      valid_in = valid_ff && !rsp_tready;
      data_in  = data_ff;
      last_in  = last_ff;
      if (stage_take) begin
         valid_in = 1'b1;
         data_in  = {mbd_pkg::ALPHA_OPAQUE, mbd_pkg::finish(top, stage.pair)};
         last_in  = stage.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

// ----- rtl/mipmap_box_downsample_unit.sv -----
// Top level of the 2x2 box-filter mip level downsampler.
// Depends on mbd_pkg, mbd_ram, mbd_scan_ctrl and mbd_out_stage.
`default_nettype none

// Source pixels enter in raster order at one per clock cycle while the output does not stall,
// without gaps at row ends; each 2x2 source block yields one opaque output pixel in raster
// order, with tlast on the final pixel of the output level. A result passes through the stage
// register and the output register; the rate of one pixel per cycle is set by the scan stage and
// the one write and one read port of the line store. The line store is one RAM of MAX_WIDTH / 2
// pair sums, written on even rows and read on odd rows, and needs no clearing after reset. Sizes
// are clamped to 1..MAX; a register write restarts the level and must be made while idle. Odd
// sizes drop the last column or row, and a size of one pairs that column or row with itself.

module mipmap_box_downsample_unit #(
   parameter int MAX_WIDTH  = mbd_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = mbd_pkg::DEFAULT_MAX_HEIGHT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Configuration write port.
   input  wire logic                              csr_we,
   input  wire logic [mbd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [mbd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // Source pixel stream.
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   input  wire logic [mbd_pkg::PIXEL_W-1:0]       req_tdata,   // src_pixel[31:0]
   // Output pixel stream.
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   output      logic [mbd_pkg::PIXEL_W-1:0]       rsp_tdata,   // out_pixel[31:0]
   output      logic                              rsp_tlast    // out_last
);

   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   logic                       line_wr_en, line_rd_en, stage_take;
   logic [AW-1:0]              line_wr_addr, line_rd_addr;
   logic [mbd_pkg::PAIR_W-1:0] line_wr_data, line_rd_data;
   mbd_pkg::stage_type         stage;

   // Counting, pairing and line store access.
   mbd_scan_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .line_wr_en   (line_wr_en),
      .line_wr_addr (line_wr_addr),
      .line_wr_data (line_wr_data),
      .line_rd_en   (line_rd_en),
      .line_rd_addr (line_rd_addr),
      .stage        (stage),
      .stage_take   (stage_take)
   );

   // Line store of even-row pair sums.
   mbd_ram #(
      .WIDTH (mbd_pkg::PAIR_W),
      .DEPTH (LINE_DEPTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (line_wr_en),
      .wr_addr (line_wr_addr),
      .wr_data (line_wr_data),
      .rd_en   (line_rd_en),
      .rd_addr (line_rd_addr),
      .rd_data (line_rd_data)
   );

   // Averaging and output register.
   mbd_out_stage u_out (
      .clock        (clock),
      .reset        (reset),
      .stage        (stage),
      .stage_take   (stage_take),
      .line_rd_data (line_rd_data),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

`default_nettype wire

// ----- rtl/mbd_checker.sv -----
// Port-level checks of the downsampler, attached to the top level by the bind below.
// Depends on mbd_pkg for field widths and the alpha constant.
`default_nettype none

module mbd_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [mbd_pkg::PIXEL_W-1:0]     rsp_tdata,
   input wire logic                            rsp_tlast
);

   // A stalled result keeps its pixel and its end-of-level flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Every output pixel is opaque.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:24] == mbd_pkg::ALPHA_OPAQUE)
      else $error("output alpha is not opaque");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered straight after reset");

endmodule

bind mipmap_box_downsample_unit mbd_checker u_mbd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
